// ===== rtl/prpt_pkg.sv =====
// shared types and constants of the pwm rotary position tracker
// used by the top level and the shared divider, no dependencies
`default_nettype none

package prpt_pkg;

   // capture field width and result field widths
   localparam int CNT_W   = 16;
   localparam int SUM_W   = 16;
   localparam int POS_W   = 13;
   localparam int DELTA_W = 8;

   // request kinds carried in tuser
   localparam logic OP_CAPTURE = 1'b0;
   localparam logic OP_REPORT  = 1'b1;

   // divider status seen by the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage : prpt_pkg

`default_nettype wire

// ===== rtl/prpt_div.sv =====
// shared restoring divider, one quotient bit per cycle
// depends on prpt_pkg for the divisor width and status struct
`default_nettype none

module prpt_div #(
   parameter int DVD_W = 29
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   input  wire logic [prpt_pkg::CNT_W-1:0]      divisor,
   input  wire logic [prpt_pkg::CNT_W-1:0]      rem_init,
   input  wire logic [DVD_W-1:0]                dvd_init,
   input  wire logic [$clog2(DVD_W+1)-1:0]      steps,
   output logic      [DVD_W-1:0]                quotient,
   output logic      [prpt_pkg::CNT_W-1:0]      remainder,
   output prpt_pkg::div_status_type             status
);

   localparam int CW = $clog2(DVD_W + 1);
   localparam int RW = prpt_pkg::CNT_W;

   logic [RW-1:0]    rem_ff, rem_in;
   logic [DVD_W-1:0] dvd_ff, dvd_in;
   logic [RW-1:0]    div_ff, div_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [RW:0]      shifted;
   logic [RW+1:0]    trial;
   logic             fits;

   // one trial subtract of the partial remainder
   always_comb begin
      shifted = {rem_ff, dvd_ff[DVD_W-1]};
      trial   = {1'b0, shifted} - {2'b00, div_ff};
      fits    = ~trial[RW+1];
   end

   always_comb begin
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = rem_init;
         dvd_in  = dvd_init;
         div_in  = divisor;
         cnt_in  = steps;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? trial[RW-1:0] : shifted[RW-1:0];
         dvd_in = {dvd_ff[DVD_W-2:0], fits};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      div_ff <= div_in;
   end

   assign quotient    = dvd_ff;
   assign remainder   = rem_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule : prpt_div

`default_nettype wire

// ===== rtl/pwm_rotary_position_tracker.sv =====
// top level of the pwm rotary position tracker: sequencer, accumulator, report logic
// depends on prpt_pkg and prpt_div
//
// Decodes an absolute rotary sensor whose angle is carried in a pwm duty cycle.
// A capture transfer (tuser 0) brings period and high time; the high time is
// first reduced modulo the period when it is larger, then position =
// high*LEVELS/period. The wrapped step from the previous position is added to
// a saturating signed 16-bit movement sum. A report transfer (tuser 1) returns
// the position (low 13 bits) and a delta clamped to -128..127; the sum is
// cleared unless its magnitude is 2 or less, in which case delta is 0. Zero
// periods are dropped; with enable low every transfer is taken and dropped.
// A capture runs the modulo, when the high time exceeds the period, and then
// the divide on one shared restoring divider that retires one bit per cycle;
// no new transfer is taken until the capture is finished. A waiting report
// does not hold up the next transfer once the downstream side takes it.
`default_nettype none

module pwm_rotary_position_tracker #(
   parameter int LEVELS = 4096
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // configuration
   input  wire logic        csr_we,
   input  wire logic        csr_wdata,   // enable
   // capture and report requests
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // [15:0] period_count, [31:16] high_count
   input  wire logic        req_tuser,   // opcode: 0 capture, 1 report
   // reports
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata    // [12:0] position, [20:13] delta, [23:21] zero
);

   localparam int CNT_W   = prpt_pkg::CNT_W;
   localparam int SUM_W   = prpt_pkg::SUM_W;
   localparam int POS_W   = prpt_pkg::POS_W;
   localparam int DELTA_W = prpt_pkg::DELTA_W;
   localparam int RSP_W   = ((POS_W + DELTA_W + 7) / 8) * 8;
   localparam int LW      = $clog2(LEVELS + 1);
   localparam int NW      = CNT_W + LW;
   localparam int CW      = $clog2(NW + 1);
   localparam int EXT_W   = (LW + 2 > SUM_W + 2) ? LW + 2 : SUM_W + 2;

   localparam logic [NW-1:0]           LEVELS_N = NW'(LEVELS);
   localparam logic [LW-1:0]           LEVELS_P = LW'(LEVELS);
   localparam logic signed [EXT_W-1:0] LEVELS_S = EXT_W'(LEVELS);
   localparam logic signed [EXT_W-1:0] HALF_S   = EXT_W'(LEVELS / 2);
   localparam logic signed [EXT_W-1:0] NEG_HALF = -HALF_S;
   localparam logic signed [EXT_W-1:0] SUM_MAX  = EXT_W'((1 << (SUM_W - 1)) - 1);
   localparam logic signed [EXT_W-1:0] SUM_MIN  = ~SUM_MAX;
   localparam logic signed [SUM_W-1:0] D_MAX    = SUM_W'(127);
   localparam logic signed [SUM_W-1:0] D_MIN    = ~D_MAX;
   localparam logic signed [SUM_W-1:0] DEAD     = SUM_W'(2);
   localparam logic signed [SUM_W-1:0] NEG_DEAD = -DEAD;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MOD,
      ST_MUL,
      ST_DSTART,
      ST_DIV,
      ST_ACC
   } state_type;

   state_type                 state_ff, state_in;
   logic                      enable_ff, enable_in;
   logic [CNT_W-1:0]          period_ff, period_in;
   logic [CNT_W-1:0]          high_ff, high_in;
   logic [NW-1:0]             prod_ff, prod_in;
   logic [LW-1:0]             pos_ff, pos_in;
   logic [LW-1:0]             last_pos_ff, last_pos_in;
   logic signed [SUM_W-1:0]   sum_ff, sum_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0]          rsp_pos_ff, rsp_pos_in;
   logic [DELTA_W-1:0]        rsp_delta_ff, rsp_delta_in;

   // request fields
   logic [CNT_W-1:0]          req_period;
   logic [CNT_W-1:0]          req_high;
   logic                      accept;

   // divider hookup
   logic                      div_start;
   logic [CNT_W-1:0]          div_divisor;
   logic [CNT_W-1:0]          div_rem_init;
   logic [NW-1:0]             div_dvd_init;
   logic [CW-1:0]             div_steps;
   logic [NW-1:0]             div_quo;
   logic [CNT_W-1:0]          div_rem;
   prpt_pkg::div_status_type  div_status;

   // accumulate path
   logic signed [EXT_W-1:0]   step_raw;
   logic signed [EXT_W-1:0]   step_wrap;
   logic signed [EXT_W-1:0]   sum_ext;

   // report path, position squeezed or padded to the field width
   logic [POS_W+LW-1:0]       pos_wide;

   assign req_period = req_tdata[CNT_W-1:0];
   assign req_high   = req_tdata[2*CNT_W-1:CNT_W];
   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign pos_wide   = {{POS_W{1'b0}}, last_pos_ff};

   // divider operands: modulo starts straight from the request, divide from the product
   always_comb begin
      div_start    = 1'b0;
      div_divisor  = req_period;
      div_rem_init = '0;
      div_dvd_init = {req_high, {LW{1'b0}}};
      div_steps    = CW'(CNT_W);
      if (state_ff == ST_IDLE) begin
         div_start = accept && enable_ff && (req_tuser == prpt_pkg::OP_CAPTURE)
                     && (req_period != '0) && (req_high > req_period);
      end else if (state_ff == ST_DSTART) begin
         // product < period * 2^LW, so its top bits already sit below the divisor
         div_start    = 1'b1;
         div_divisor  = period_ff;
         div_rem_init = prod_ff[NW-1:LW];
         div_dvd_init = {prod_ff[LW-1:0], {CNT_W{1'b0}}};
         div_steps    = CW'(LW);
      end
   end

   prpt_div #(
      .DVD_W (NW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .divisor   (div_divisor),
      .rem_init  (div_rem_init),
      .dvd_init  (div_dvd_init),
      .steps     (div_steps),
      .quotient  (div_quo),
      .remainder (div_rem),
      .status    (div_status)
   );

   // wrap the step into +-LEVELS/2 and add it to the widened running sum; ST_ACC saturates it
   always_comb begin
      step_raw = $signed({{(EXT_W-LW){1'b0}}, pos_ff})
               - $signed({{(EXT_W-LW){1'b0}}, last_pos_ff});
      if (step_raw > HALF_S) begin
         step_wrap = step_raw - LEVELS_S;
      end else if (step_raw < NEG_HALF) begin
         step_wrap = step_raw + LEVELS_S;
      end else begin
         step_wrap = step_raw;
      end
      sum_ext = $signed({{(EXT_W-SUM_W){sum_ff[SUM_W-1]}}, sum_ff}) + step_wrap;
   end

   always_comb begin
      state_in     = state_ff;
      enable_in    = csr_we ? csr_wdata : enable_ff;
      period_in    = period_ff;
      high_in      = high_ff;
      prod_in      = prod_ff;
      pos_in       = pos_ff;
      last_pos_in  = last_pos_ff;
      sum_in       = sum_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_pos_in   = rsp_pos_ff;
      rsp_delta_in = rsp_delta_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept && enable_ff) begin
               if (req_tuser == prpt_pkg::OP_REPORT) begin
                  rsp_valid_in = 1'b1;
                  rsp_pos_in   = pos_wide[POS_W-1:0];
                  if (sum_ff > D_MAX) begin
                     rsp_delta_in = D_MAX[DELTA_W-1:0];
                     sum_in       = '0;
                  end else if (sum_ff < D_MIN) begin
                     rsp_delta_in = D_MIN[DELTA_W-1:0];
                     sum_in       = '0;
                  end else if (sum_ff > DEAD || sum_ff < NEG_DEAD) begin
                     rsp_delta_in = sum_ff[DELTA_W-1:0];
                     sum_in       = '0;
                  end else begin
                     // small jitter stays in the sum
                     rsp_delta_in = '0;
                  end
               end else if (req_period != '0) begin
                  period_in = req_period;
                  high_in   = req_high;
                  state_in  = (req_high > req_period) ? ST_MOD : ST_MUL;
               end
            end
         end
         ST_MOD: begin
            if (div_status.done) begin
               high_in  = div_rem;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = NW'(high_ff) * LEVELS_N;
            state_in = ST_DSTART;
         end
         ST_DSTART: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_status.done) begin
               pos_in   = div_quo[LW-1:0];
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            last_pos_in = pos_ff;
            if (sum_ext > SUM_MAX) begin
               sum_in = SUM_MAX[SUM_W-1:0];
            end else if (sum_ext < SUM_MIN) begin
               sum_in = SUM_MIN[SUM_W-1:0];
            end else begin
               sum_in = sum_ext[SUM_W-1:0];
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         enable_ff    <= 1'b0;
         last_pos_ff  <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         enable_ff    <= enable_in;
         last_pos_ff  <= last_pos_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      period_ff    <= period_in;
      high_ff      <= high_in;
      prod_ff      <= prod_in;
      pos_ff       <= pos_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_delta_ff <= rsp_delta_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_W-POS_W-DELTA_W){1'b0}}, rsp_delta_ff, rsp_pos_ff};

   // the divider never runs while new transfers are taken
   a_ready_div_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !div_status.busy)
      else $error("request taken while divider busy");

   // a divide result only lands in a state that waits for it
   a_done_expected: assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> (state_ff == ST_MOD || state_ff == ST_DIV))
      else $error("divider finished outside a waiting state");

   // the tracked position never passes full scale
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      last_pos_ff <= LEVELS_P)
      else $error("position beyond full scale");

   // a report only appears after an accepted report request
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(accept && enable_ff && req_tuser == prpt_pkg::OP_REPORT))
      else $error("report without a report request");

endmodule : pwm_rotary_position_tracker

`default_nettype wire

// ===== dv/tb_pwm_rotary_position_tracker.sv =====
`timescale 1ns / 100ps
// self-checking bench for the pwm rotary position tracker: directed and random capture/report
// streams checked against a behavioural tracker. depends on prpt_pkg and the tracker rtl

module tb_pwm_rotary_position_tracker;

   localparam int   CNT_W         = prpt_pkg::CNT_W;
   localparam int   SUM_W         = prpt_pkg::SUM_W;
   localparam int   POS_W         = prpt_pkg::POS_W;
   localparam int   DELTA_W       = prpt_pkg::DELTA_W;
   localparam logic OP_CAPTURE    = prpt_pkg::OP_CAPTURE;
   localparam logic OP_REPORT     = prpt_pkg::OP_REPORT;

   localparam int LEVELS          = 4096;
   localparam int SUM_MAX         = 2 ** (SUM_W - 1) - 1;
   localparam int SUM_MIN         = -(2 ** (SUM_W - 1));
   localparam int DELTA_MAX       = 127;
   localparam int DELTA_MIN       = -128;
   localparam int DEAD_BAND       = 2;
   localparam int CAPTURE_LATENCY = 64;      // longest capture (modulo plus divide) with margin
   localparam int CYCLE_LIMIT     = 800000;

   typedef struct {
      logic               op;
      logic [CNT_W-1:0]   period;
      logic [CNT_W-1:0]   high;
   } sensor_req_type;

   typedef struct {
      logic [POS_W-1:0]   position;
      logic [DELTA_W-1:0] delta;
   } report_type;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   // dut ports
   logic        csr_we     = 1'b0;
   logic        csr_wdata  = 1'b0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;     // [15:0] period_count, [31:16] high_count
   logic        req_tuser  = 1'b0;   // opcode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;           // [12:0] position, [20:13] delta

   // pending requests and outstanding reports
   sensor_req_type pending_reqs[$];
   report_type     expected_reports[$];

   // tracker state as the bench sees it
   logic tracked_enable;
   int   tracked_position;
   int   tracked_sum;

   // bookkeeping
   int unsigned queued_total   = 0;
   int unsigned accepted_total = 0;
   int unsigned counted_items  = 0;
   int unsigned reports_seen   = 0;
   int unsigned error_count    = 0;
   int unsigned cycle_count    = 0;
   int unsigned saturations    = 0;
   int unsigned clamps         = 0;
   int unsigned held_sums      = 0;
   logic        enable_setting = 1'b0;
   logic        idle_on        = 1'b1;
   logic        req_taken      = 1'b0;
   int          send_gap       = 0;
   int          ready_stall    = 0;

   pwm_rotary_position_tracker #(
      .LEVELS(LEVELS)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // works out the effect of one accepted request on position and movement sum,
   // queueing a report where one is due
   function automatic void track_request(input sensor_req_type r);
      logic [31:0] high_eff;
      int          pos;
      int          step;
      int          sum;
      int          delta;
      report_type  rep;
      if (!tracked_enable) return;
      if (r.op == OP_CAPTURE) begin
         // zero period: capture dropped, state kept
         if (r.period == '0) return;
         high_eff = 32'(r.high);
         if (r.high > r.period) high_eff = 32'(r.high % r.period);
         pos = int'((high_eff * LEVELS) / 32'(r.period));
         // shortest way round the dial
         step = pos - tracked_position;
         if (step > LEVELS / 2) step -= LEVELS;
         if (step < -(LEVELS / 2)) step += LEVELS;
         tracked_position = pos;
         sum = tracked_sum + step;
         if (sum > SUM_MAX) begin
            sum = SUM_MAX;
            saturations++;
         end
         if (sum < SUM_MIN) begin
            sum = SUM_MIN;
            saturations++;
         end
         tracked_sum = sum;
         return;
      end
      // report: clamp and clear, or hold a sum inside the dead band
      if (tracked_sum > DELTA_MAX) begin
         delta = DELTA_MAX;
         tracked_sum = 0;
         clamps++;
      end else if (tracked_sum < DELTA_MIN) begin
         delta = DELTA_MIN;
         tracked_sum = 0;
         clamps++;
      end else if (tracked_sum > DEAD_BAND || tracked_sum < -DEAD_BAND) begin
         delta = tracked_sum;
         tracked_sum = 0;
      end else begin
         delta = 0;
         held_sums++;
      end
      rep.position = POS_W'(tracked_position);
      rep.delta    = DELTA_W'(delta);
      expected_reports.push_back(rep);
   endfunction

   // request driver: presents queued requests at the falling edge, with random gaps while idle_on is set
   always @(negedge clock) begin : driver
      sensor_req_type next_req;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (send_gap > 0) begin
            req_tvalid <= 1'b0;
            send_gap--;
         end else if (idle_on && pending_reqs.size() != 0 && $urandom_range(0, 4) == 0) begin
            req_tvalid <= 1'b0;
            send_gap = $urandom_range(0, 5);
         end else if (pending_reqs.size() != 0) begin
            next_req = pending_reqs.pop_front();
            req_tuser  <= next_req.op;
            req_tdata  <= {next_req.high, next_req.period};
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // report receiver: back-pressure in random bursts while idle_on is set
   always @(negedge clock) begin : receiver
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (ready_stall > 0) begin
         rsp_tready <= 1'b0;
         ready_stall--;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
         rsp_tready <= 1'b0;
         ready_stall = $urandom_range(0, 5);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // monitor: follows register writes, predicts on each request transfer and
   // checks each report transfer against the oldest outstanding report
   always @(posedge clock) begin : monitor
      report_type     want;
      sensor_req_type got;
      if (reset) begin
         tracked_enable   = 1'b0;
         tracked_position = 0;
         tracked_sum      = 0;
         req_taken       <= 1'b0;
      end else begin
         req_taken <= req_tvalid && req_tready;
         if (csr_we) tracked_enable = csr_wdata;
         if (rsp_tvalid && rsp_tready) begin
            reports_seen++;
            if (expected_reports.size() == 0) begin
               $error("report with none outstanding: position %0d delta %0d",
                      rsp_tdata[12:0], $signed(rsp_tdata[20:13]));
               error_count++;
            end else begin
               want = expected_reports.pop_front();
               if (rsp_tdata[12:0] !== want.position) begin
                  $error("position: expected %0d, actual %0d", want.position, rsp_tdata[12:0]);
                  error_count++;
               end
               if (rsp_tdata[20:13] !== want.delta) begin
                  $error("delta: expected %0d, actual %0d",
                         $signed(want.delta), $signed(rsp_tdata[20:13]));
                  error_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            got.op     = req_tuser;
            got.period = req_tdata[15:0];
            got.high   = req_tdata[31:16];
            track_request(got);
            accepted_total++;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $error("timeout after %0d cycles, %0d reports outstanding",
                cycle_count, expected_reports.size());
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic push_req(input logic op, input int period, input int high);
      sensor_req_type r;
      r.op     = op;
      r.period = CNT_W'(period);
      r.high   = CNT_W'(high);
      pending_reqs.push_back(r);
      queued_total++;
      if (enable_setting) counted_items++;
   endtask

   // holds the sender until every transfer is in and every report is out,
   // then lets a capture still in the divider finish
   task automatic wait_quiet();
      while (queued_total != accepted_total || expected_reports.size() != 0)
         @(negedge clock);
      repeat (CAPTURE_LATENCY) @(negedge clock);
   endtask

   task automatic write_enable(input logic value);
      wait_quiet();
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      enable_setting = value;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // random traffic until the enabled-item count reaches the target
   task automatic random_traffic(input int unsigned target);
      int kind;
      int n;
      int period;
      int high;
      int walk;
      int dir;
      while (counted_items < target) begin
         kind = $urandom_range(0, 9);
         case (kind)
            0, 1, 2, 3: begin
               // tracking run: one period, several captures, then a report
               case ($urandom_range(0, 5))
                  0:       period = $urandom_range(1, 64);
                  1:       period = 65535;
                  default: period = $urandom_range(500, 65535);
               endcase
               n = $urandom_range(1, 8);
               repeat (n) begin
                  if ($urandom_range(0, 5) == 0) high = $urandom_range(period, 65535);
                  else high = $urandom_range(0, period);
                  push_req(OP_CAPTURE, period, high);
               end
               push_req(OP_REPORT, $urandom, $urandom);
            end
            4, 5: begin
               // slow drift around the dead band, frequent reports
               walk = $urandom_range(0, LEVELS);
               repeat ($urandom_range(4, 16)) begin
                  if ($urandom_range(0, 1)) begin
                     push_req(OP_REPORT, $urandom, $urandom);
                  end else begin
                     walk += $urandom_range(0, 6) - 3;
                     if (walk < 0) walk = 0;
                     if (walk > LEVELS) walk = LEVELS;
                     push_req(OP_CAPTURE, LEVELS, walk);
                  end
               end
            end
            6: begin
               // long one-way spin without reports drives the sum toward saturation
               walk = $urandom_range(0, LEVELS - 1);
               dir  = $urandom_range(0, 1);
               repeat ($urandom_range(18, 24)) begin
                  if (dir) walk = (walk + $urandom_range(1800, 2040)) % LEVELS;
                  else walk = (walk + LEVELS - $urandom_range(1800, 2040)) % LEVELS;
                  push_req(OP_CAPTURE, LEVELS, walk);
               end
               push_req(OP_REPORT, $urandom, $urandom);
            end
            7, 8: begin
               // noise: any opcode, any counts, zero periods included
               repeat ($urandom_range(8, 16)) begin
                  period = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(0, 65535);
                  push_req(logic'($urandom_range(0, 1)), period, $urandom_range(0, 65535));
               end
            end
            default: begin
               // hold-off: sender waits for the pipe to empty
               wait_quiet();
            end
         endcase
         while (pending_reqs.size() > 24) @(negedge clock);
      end
   endtask

   initial begin : stimulus
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // out of reset the tracker is disabled: all transfers dropped
      push_req(OP_CAPTURE, 1000, 500);
      push_req(OP_REPORT, 0, 0);
      push_req(OP_CAPTURE, 65535, 65535);
      write_enable(1'b1);

      // directed
      push_req(OP_REPORT, $urandom, $urandom);    // reset state
      push_req(OP_CAPTURE, 0, 1234);              // zero period ignored
      push_req(OP_CAPTURE, 1000, 1000);           // high equal to period
      push_req(OP_REPORT, $urandom, $urandom);
      push_req(OP_CAPTURE, 65535, 65535);
      push_req(OP_CAPTURE, 65535, 0);
      push_req(OP_CAPTURE, 1, 65535);             // high above period, modulo
      push_req(OP_CAPTURE, 100, 150);             // half turn forward
      push_req(OP_REPORT, $urandom, $urandom);    // clamp high
      push_req(OP_CAPTURE, 100, 101);
      push_req(OP_REPORT, $urandom, $urandom);    // clamp low
      push_req(OP_CAPTURE, 1000, 1);
      push_req(OP_REPORT, $urandom, $urandom);    // plain negative delta
      push_req(OP_CAPTURE, LEVELS, 6);
      push_req(OP_REPORT, $urandom, $urandom);    // +2 held
      push_req(OP_CAPTURE, LEVELS, 7);
      push_req(OP_REPORT, $urandom, $urandom);    // +3 reported
      push_req(OP_CAPTURE, LEVELS, 5);
      push_req(OP_REPORT, $urandom, $urandom);    // -2 held
      push_req(OP_CAPTURE, LEVELS, 4);
      push_req(OP_REPORT, $urandom, $urandom);    // -3 reported
      push_req(OP_CAPTURE, LEVELS, 50);
      push_req(OP_REPORT, $urandom, $urandom);
      wait_quiet();

      random_traffic(900);

      // disabled phase: state must survive it untouched
      write_enable(1'b0);
      repeat (40) push_req(logic'($urandom_range(0, 1)), $urandom, $urandom);
      write_enable(1'b0);
      write_enable(1'b1);
      random_traffic(1600);

      // last stretch at full rate on both sides
      wait_quiet();
      idle_on = 1'b0;
      random_traffic(1900);
      wait_quiet();

      $display("covered %0d request transfers (%0d enabled), %0d reports checked",
               accepted_total, counted_items, reports_seen);
      $display("sum saturated %0d times, delta clamped %0d times, dead band held %0d times",
               saturations, clamps, held_sums);
      if (error_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ===== pwm_rotary_position_tracker.f =====
rtl/prpt_pkg.sv
rtl/prpt_div.sv
rtl/pwm_rotary_position_tracker.sv
dv/tb_pwm_rotary_position_tracker.sv
